FILE: sv/tts_pkg.sv
package tts_pkg;

  localparam int SLOTS   = 16;
  localparam int TICK_MS = 10;
  localparam int MAX_OUT = 16;

  localparam int MS_W     = 32;
  localparam int TASK_W   = 8;
  localparam int PEND_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int NOUT_W   = $clog2(MAX_OUT + 1);

  // ms to ticks by reciprocal multiply: ceil(2^RECIP_SH / TICK_MS) gives an exact
  // floor quotient for every MS_W-bit dividend
  localparam int RECIP_W  = MS_W + 1;
  localparam int RECIP_SH = MS_W + $clog2(TICK_MS);
  localparam int MUL_W    = MS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_DEL  = 2'd1,
    K_TICK = 2'd2,
    K_DISP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_id;
    logic [MS_W-1:0]   delay;
    logic [MS_W-1:0]   period;
    logic [PEND_W-1:0] pending;
  } slot_t;

  typedef struct packed {
    kind_t             kind;
    logic [TASK_W-1:0] task_id;
    logic [MS_W-1:0]   dly;
    logic [MS_W-1:0]   per;
    logic              found;
    logic              match;
    logic              room;
  } alu_op_t;

  typedef struct packed {
    logic              take;
    logic              hit;
    logic              emit;
    logic [TASK_W-1:0] task_id;
    logic [PEND_W-1:0] left;
  } alu_flags_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
    logic [TASK_W-1:0] task_out;
    logic [PEND_W-1:0] runs_left;
    logic              last;
  } result_t;

endpackage

FILE: sv/tts_cmd_if.sv
interface tts_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [tts_pkg::SLOT_W-1:0] slot;
  logic [tts_pkg::TASK_W-1:0] task_id;
  logic [tts_pkg::MS_W-1:0]   delay_ms;
  logic [tts_pkg::MS_W-1:0]   period_ms;

  modport source(output valid, kind, slot, task_id, delay_ms, period_ms, input ready);
  modport sink(input valid, kind, slot, task_id, delay_ms, period_ms, output ready);
endinterface

FILE: sv/tts_rsp_if.sv
interface tts_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [tts_pkg::SLOT_W-1:0] slot_out;
  logic [tts_pkg::TASK_W-1:0] task_out;
  logic [tts_pkg::PEND_W-1:0] runs_left;
  logic                       last;

  modport source(output valid, status, slot_out, task_out, runs_left, last, input ready);
  modport sink(input valid, status, slot_out, task_out, runs_left, last, output ready);
endinterface

FILE: sv/tts_cell.sv
module tts_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  tts_pkg::slot_t d,
  output tts_pkg::slot_t q
);
  import tts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: sv/tts_div.sv
module tts_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tts_pkg::MS_W-1:0] dly_ms,
  input  logic [tts_pkg::MS_W-1:0] per_ms,
  output logic                     done,
  output logic [tts_pkg::MS_W-1:0] dly_q,
  output logic [tts_pkg::MS_W-1:0] per_q
);
  import tts_pkg::*;

  logic             busy;
  logic             phase;
  logic [MS_W-1:0]  opnd;
  logic [MS_W-1:0]  per_hold;
  logic [MUL_W-1:0] mul;
  logic [MS_W-1:0]  quo;

  // one shared multiplier: delay while phase is low, period while phase is high
  assign mul  = MUL_W'(opnd) * MUL_W'(RECIP_M);
  assign quo  = MS_W'(mul >> RECIP_SH);
  assign done = busy && phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (busy) begin
      phase <= !phase;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd     <= dly_ms;
      per_hold <= per_ms;
    end else if (busy && !phase) begin
      dly_q <= quo;
      opnd  <= per_hold;
    end else if (done) begin
      per_q <= quo;
    end
  end

endmodule

FILE: sv/tts_slot_alu.sv
module tts_slot_alu (
  input  tts_pkg::slot_t      head,
  input  tts_pkg::alu_op_t    op,
  output tts_pkg::slot_t      nxt,
  output tts_pkg::alu_flags_t fl
);
  import tts_pkg::*;

  logic [MS_W-1:0] d;

  always_comb begin
    nxt = head;
    fl  = '0;
    d   = head.delay;
    case (op.kind)
      K_ADD: begin
        if (!op.found && !head.valid) begin
          nxt.valid   = 1'b1;
          nxt.task_id = op.task_id;
          nxt.delay   = op.dly;
          nxt.period  = op.per;
          nxt.pending = '0;
          fl.take     = 1'b1;
        end
      end
      K_DEL: begin
        if (op.match) begin
          fl.hit = head.valid;
          nxt    = '0;
        end
      end
      K_TICK: begin
        if (head.valid) begin
          if (head.delay != '0) begin
            d = head.delay - 1'b1;
          end
          if (d == '0) begin
            if (head.pending != '1) begin
              nxt.pending = head.pending + 1'b1;
            end
            if (head.period != '0) begin
              d = head.period;
            end
          end
          nxt.delay = d;
        end
      end
      K_DISP: begin
        if (head.valid && head.pending != '0 && op.room) begin
          fl.emit    = 1'b1;
          fl.task_id = head.task_id;
          if (head.period == '0) begin
            nxt = '0;
          end else begin
            nxt.pending = head.pending - 1'b1;
            fl.left     = head.pending - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/tick_task_scheduler_unit.sv
// Sequence: an add first scales delay and period through the divider; then every command
//   scans the ring slot by slot past the single update unit and posts a final beat.
// Flow: a new command is accepted only in idle, once the previous one has posted its final
//   beat; the ring rotates one slot per cycle, but a stalled output freezes the ring during
//   dispatch and holds back the final beat.
// Reset: synchronous; every slot is cleared at once and the block is ready the next cycle.
module tick_task_scheduler_unit (
  input logic      clk,
  input logic      rst,
  tts_cmd_if.sink  cmd,
  tts_rsp_if.source rsp
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  kind_t             op_kind;
  logic [SLOT_W-1:0] del_slot;
  logic [TASK_W-1:0] op_task;
  logic              found;
  logic              hit;
  logic [SLOT_W-1:0] add_slot;
  logic [NOUT_W-1:0] nout;
  logic              hold_v;
  result_t           hold;
  logic              ob_v;
  result_t           ob;

  logic              accept;
  logic              can_load;
  logic              step;
  logic              scan_done;
  logic              fin_go;
  logic              ob_load;
  result_t           ob_d;
  result_t           emit_res;
  result_t           fin_res;
  logic [CNT_W+3:0]  cnt_ext;
  logic [SLOT_W-1:0] cnt_lo;

  logic              div_done;
  logic [MS_W-1:0]   dly_t;
  logic [MS_W-1:0]   per_t;

  slot_t             chain [SLOTS];
  slot_t             chain_d [SLOTS];
  slot_t             alu_nxt;
  alu_op_t           aop;
  alu_flags_t        fl;

  tts_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && kind_t'(cmd.kind) == K_ADD),
    .dly_ms (cmd.delay_ms),
    .per_ms (cmd.period_ms),
    .done   (div_done),
    .dly_q  (dly_t),
    .per_q  (per_t)
  );

  // slot ring: head is cell 0, updated record re-enters at the tail
  for (genvar k = 0; k < SLOTS; k++) begin : g_ring
    if (k == SLOTS - 1) begin : g_tail
      assign chain_d[k] = alu_nxt;
    end else begin : g_mid
      assign chain_d[k] = chain[k+1];
    end
    tts_cell u_slot (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d     (chain_d[k]),
      .q     (chain[k])
    );
  end

  assign cnt_ext = {4'b0, cnt};
  assign cnt_lo  = cnt_ext[SLOT_W-1:0];

  always_comb begin
    aop.kind    = op_kind;
    aop.task_id = op_task;
    aop.dly     = dly_t;
    aop.per     = per_t;
    aop.found   = found;
    aop.match   = (cnt_ext == {CNT_W'(0), del_slot});
    aop.room    = (nout < NOUT_W'(MAX_OUT));
  end

  tts_slot_alu u_alu (
    .head (chain[0]),
    .op   (aop),
    .nxt  (alu_nxt),
    .fl   (fl)
  );

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign can_load  = !ob_v || rsp.ready;
  // an emit with a beat already held needs room in the output register
  assign step      = (state == S_SCAN) && !(fl.emit && hold_v && !can_load);
  assign scan_done = step && (cnt == CNT_W'(SLOTS - 1));
  assign fin_go    = (state == S_FIN) && can_load;
  assign ob_load   = (step && fl.emit && hold_v) || fin_go;
  assign ob_d      = fin_go ? fin_res : hold;

  always_comb begin
    emit_res           = '0;
    emit_res.status    = ST_OK;
    emit_res.slot_out  = cnt_lo;
    emit_res.task_out  = fl.task_id;
    emit_res.runs_left = fl.left;
    emit_res.last      = 1'b0;
  end

  always_comb begin
    fin_res      = '0;
    fin_res.last = 1'b1;
    case (op_kind)
      K_ADD: begin
        fin_res.status   = found ? ST_OK : ST_FULL;
        fin_res.slot_out = found ? add_slot : '0;
      end
      K_DEL: begin
        fin_res.status   = hit ? ST_OK : ST_EMPTY;
        fin_res.slot_out = del_slot;
      end
      K_TICK: begin
        fin_res.status = ST_OK;
      end
      K_DISP: begin
        if (hold_v) begin
          fin_res      = hold;
          fin_res.last = 1'b1;
        end else begin
          fin_res.status = ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      found  <= 1'b0;
      hit    <= 1'b0;
      nout   <= '0;
      hold_v <= 1'b0;
      ob_v   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cnt    <= '0;
            found  <= 1'b0;
            hit    <= 1'b0;
            nout   <= '0;
            hold_v <= 1'b0;
            state  <= (kind_t'(cmd.kind) == K_ADD) ? S_DIV : S_SCAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step) begin
            cnt <= cnt + 1'b1;
            if (fl.take) begin
              found <= 1'b1;
            end
            if (fl.hit) begin
              hit <= 1'b1;
            end
            if (fl.emit) begin
              nout   <= nout + 1'b1;
              hold_v <= 1'b1;
            end
            if (scan_done) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (can_load) begin
            hold_v <= 1'b0;
            cnt    <= '0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ob_load) begin
        ob_v <= 1'b1;
      end else if (rsp.ready) begin
        ob_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind  <= kind_t'(cmd.kind);
      del_slot <= cmd.slot;
      op_task  <= cmd.task_id;
    end
    if (step && fl.take) begin
      add_slot <= cnt_lo;
    end
    if (step && fl.emit) begin
      hold <= emit_res;
    end
    if (ob_load) begin
      ob <= ob_d;
    end
  end

  assign rsp.valid     = ob_v;
  assign rsp.status    = ob.status;
  assign rsp.slot_out  = ob.slot_out;
  assign rsp.task_out  = ob.task_out;
  assign rsp.runs_left = ob.runs_left;
  assign rsp.last      = ob.last;

`ifndef NO_ASSERTIONS
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> ob_v && ob.last)
    else $error("final beat not posted with last");

  a_hold_disp: assert property (@(posedge clk) disable iff (rst)
    hold_v |-> op_kind == K_DISP)
    else $error("held beat outside dispatch");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt < CNT_W'(SLOTS))
    else $error("scan index past last slot");

  a_nout_cap: assert property (@(posedge clk) disable iff (rst)
    nout <= NOUT_W'(MAX_OUT))
    else $error("dispatch beat count over cap");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !hold_v && cnt == '0)
    else $error("idle with scan residue");
`endif

endmodule

FILE: tb/tick_task_scheduler_unit_tb.sv
`timescale 1ns / 1ps

module tick_task_scheduler_unit_tb;
  import tts_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_LEN   = 60;
  localparam int HOLD_LEN     = 400;
  localparam int RANDOM_ITEMS = 210;
  localparam int SAT_TICKS    = 258;

  logic clk;
  logic rst;
  logic hold_rx;
  bit   tx_idle;
  bit   rx_idle;
  int   errors;
  int   cycles;

  tts_cmd_if cmd_bus();
  tts_rsp_if rsp_bus();

  tick_task_scheduler_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  // Shadow copy of the slot table and the results it still owes
  slot_t   sched_tbl[SLOTS];
  result_t due_results[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void queue_result(status_t st, logic [SLOT_W-1:0] sl,
                                       logic [TASK_W-1:0] tk, logic [PEND_W-1:0] left,
                                       logic lst);
    result_t r;
    r.status    = st;
    r.slot_out  = sl;
    r.task_out  = tk;
    r.runs_left = left;
    r.last      = lst;
    due_results.push_back(r);
  endfunction

  function automatic void predict_schedule(kind_t k, logic [SLOT_W-1:0] sl,
                                           logic [TASK_W-1:0] tid, logic [MS_W-1:0] dms,
                                           logic [MS_W-1:0] pms);
    int i;
    int n;
    logic [PEND_W-1:0] left;
    status_t st;
    case (k)
      K_ADD: begin
        for (i = 0; i < SLOTS; i++)
          if (!sched_tbl[i].valid) break;
        if (i == SLOTS) begin
          queue_result(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          sched_tbl[i].valid   = 1'b1;
          sched_tbl[i].task_id = tid;
          sched_tbl[i].delay   = dms / 32'(TICK_MS);
          sched_tbl[i].period  = pms / 32'(TICK_MS);
          sched_tbl[i].pending = '0;
          queue_result(ST_OK, SLOT_W'(i), '0, '0, 1'b1);
        end
      end
      K_DEL: begin
        st = ST_EMPTY;
        if (int'(sl) < SLOTS) begin
          st = sched_tbl[sl].valid ? ST_OK : ST_EMPTY;
          sched_tbl[sl] = '0;
        end
        queue_result(st, sl, '0, '0, 1'b1);
      end
      K_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!sched_tbl[i].valid) continue;
          if (sched_tbl[i].delay != 0) sched_tbl[i].delay--;
          if (sched_tbl[i].delay == 0) begin
            if (sched_tbl[i].pending != 8'hFF) sched_tbl[i].pending++;
            if (sched_tbl[i].period != 0) sched_tbl[i].delay = sched_tbl[i].period;
          end
        end
        queue_result(ST_OK, '0, '0, '0, 1'b1);
      end
      default: begin
        n = 0;
        for (i = 0; i < SLOTS && n < MAX_OUT; i++) begin
          if (!sched_tbl[i].valid || sched_tbl[i].pending == 0) continue;
          sched_tbl[i].pending--;
          left = sched_tbl[i].pending;
          n++;
          // last flag is patched onto the final beat below
          queue_result(ST_OK, SLOT_W'(i), sched_tbl[i].task_id,
                       (sched_tbl[i].period == 0) ? '0 : left, 1'b0);
          if (sched_tbl[i].period == 0) sched_tbl[i] = '0;
        end
        if (n == 0) queue_result(ST_NONE, '0, '0, '0, 1'b1);
        else due_results[due_results.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  task automatic send_cmd(kind_t k, logic [SLOT_W-1:0] sl, logic [TASK_W-1:0] tid,
                          logic [MS_W-1:0] dms, logic [MS_W-1:0] pms);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.kind      <= k;
    cmd_bus.slot      <= sl;
    cmd_bus.task_id   <= tid;
    cmd_bus.delay_ms  <= dms;
    cmd_bus.period_ms <= pms;
    do @(posedge clk); while (!cmd_bus.ready);
    predict_schedule(k, sl, tid, dms, pms);
  endtask

  task automatic wait_quiet();
    cmd_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  // Receiver: per-beat random stall, plus an external hold for back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_bus.valid && rsp_bus.ready) stall_left = rx_idle ? $urandom_range(0, 10) : 0;
      else if (stall_left > 0) stall_left--;
      rsp_bus.ready <= !rst && !hold_rx && stall_left == 0;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected beat: status %0d slot %0d", rsp_bus.status, rsp_bus.slot_out);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          errors++;
        end
        if (rsp_bus.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, rsp_bus.slot_out);
          errors++;
        end
        if (rsp_bus.task_out !== want.task_out) begin
          $error("task_out: expected %0d, got %0d", want.task_out, rsp_bus.task_out);
          errors++;
        end
        if (rsp_bus.runs_left !== want.runs_left) begin
          $error("runs_left: expected %0d, got %0d", want.runs_left, rsp_bus.runs_left);
          errors++;
        end
        if (rsp_bus.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_cmd(K_DISP, '0, '0, '0, '0);
    send_cmd(K_TICK, '0, '0, '0, '0);
    send_cmd(K_DEL, 4'd15, '0, '0, '0);
    wait_quiet();
  endtask

  // Fill every slot with a task that fires on the first tick, then overflow the table
  task automatic test_fill_and_dispatch();
    logic [MS_W-1:0] pers[4];
    logic [MS_W-1:0] dlys[4];
    int i;
    pers = '{32'd0, 32'd9, 32'd10, 32'hFFFF_FFFF};
    dlys = '{32'd0, 32'd5, 32'd10, 32'd19};
    for (i = 0; i < SLOTS; i++)
      send_cmd(K_ADD, '0, (i == 0) ? 8'd0 : (i == 1) ? 8'hFF : TASK_W'($urandom_range(0, 255)),
               dlys[i % 4], pers[(i / 4) % 4]);
    send_cmd(K_ADD, '0, 8'hA5, 32'd0, 32'd10);
    send_cmd(K_TICK, '0, '0, '0, '0);
    send_cmd(K_DISP, '0, '0, '0, '0);
    send_cmd(K_DEL, 4'd8, '0, '0, '0);
    send_cmd(K_DEL, 4'd0, '0, '0, '0);
    send_cmd(K_ADD, '0, 8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_quiet();
  endtask

  // Long tick run without idling: pending counts must stop at 255
  task automatic test_pending_saturation();
    int i;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (i = 0; i < SLOTS; i++) send_cmd(K_DEL, SLOT_W'(i), '0, '0, '0);
    send_cmd(K_ADD, '0, 8'h11, 32'd3, 32'd4);
    send_cmd(K_ADD, '0, 8'h22, 32'd0, 32'd15);
    for (i = 0; i < SAT_TICKS; i++) send_cmd(K_TICK, '0, '0, '0, '0);
    send_cmd(K_DISP, '0, '0, '0, '0);
    send_cmd(K_DISP, '0, '0, '0, '0);
    wait_quiet();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Receiver blocks for a long stretch while commands keep coming
  task automatic test_backpressure();
    tx_idle = 1'b0;
    hold_rx <= 1'b1;
    fork
      begin
        repeat (HOLD_LEN) @(posedge clk);
        hold_rx <= 1'b0;
      end
      begin
        send_cmd(K_ADD, '0, 8'h31, 32'd0, 32'd10);
        send_cmd(K_ADD, '0, 8'h32, 32'd0, 32'd0);
        send_cmd(K_ADD, '0, 8'h33, 32'd10, 32'd20);
        send_cmd(K_TICK, '0, '0, '0, '0);
        send_cmd(K_TICK, '0, '0, '0, '0);
        send_cmd(K_DISP, '0, '0, '0, '0);
        send_cmd(K_TICK, '0, '0, '0, '0);
        send_cmd(K_DISP, '0, '0, '0, '0);
      end
    join
    wait_quiet();
    tx_idle = 1'b1;
  endtask

  function automatic logic [MS_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return MS_W'($urandom_range(0, 60));
    if (r < 85) return MS_W'($urandom_range(0, 200));
    return $urandom;
  endfunction

  function automatic logic [MS_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return MS_W'($urandom_range(0, 9));
    if (r < 80) return MS_W'($urandom_range(10, 80));
    return $urandom;
  endfunction

  task automatic test_random_mix();
    int n;
    int r;
    int tries;
    logic [SLOT_W-1:0] sl;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_cmd(K_ADD, SLOT_W'($urandom), TASK_W'($urandom), pick_delay(), pick_period());
      end else if (r < 45) begin
        // mostly hit a live slot so deletes do real work
        sl = SLOT_W'($urandom);
        tries = 0;
        while (!sched_tbl[sl].valid && tries < 4 && $urandom_range(0, 3) != 0) begin
          sl = SLOT_W'($urandom);
          tries++;
        end
        send_cmd(K_DEL, sl, TASK_W'($urandom), $urandom, $urandom);
      end else if (r < 80) begin
        send_cmd(K_TICK, SLOT_W'($urandom), TASK_W'($urandom), $urandom, $urandom);
      end else begin
        send_cmd(K_DISP, SLOT_W'($urandom), TASK_W'($urandom), $urandom, $urandom);
      end
    end
    wait_quiet();
  endtask

  initial begin
    int i;
    rst               = 1'b1;
    hold_rx           = 1'b0;
    tx_idle           = 1'b1;
    rx_idle           = 1'b1;
    errors            = 0;
    cycles            = 0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.kind      = K_TICK;
    cmd_bus.slot      = '0;
    cmd_bus.task_id   = '0;
    cmd_bus.delay_ms  = '0;
    cmd_bus.period_ms = '0;
    for (i = 0; i < SLOTS; i++) sched_tbl[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_and_dispatch();
    test_pending_saturation();
    test_backpressure();
    test_random_mix();

    if (due_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
